// File: rtl/four_channel_dma_address_engine_assert.svh
// ----------------------------------------------------------------------------
// DMA address engine assertion macros
// Concurrent check helpers; empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef FOUR_CHANNEL_DMA_ADDRESS_ENGINE_ASSERT_SVH
`define FOUR_CHANNEL_DMA_ADDRESS_ENGINE_ASSERT_SVH
`ifndef SYNTH
`define DAE_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define DAE_ASSERT_NORST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define DAE_ASSERT(label, clk, rstn, prop)
`define DAE_ASSERT_NORST(label, clk, prop)
`endif
`endif

// File: rtl/dae_pkg.sv
// ----------------------------------------------------------------------------
// DMA address engine package
// Shared types and constants.
// ----------------------------------------------------------------------------
`default_nettype none
package dae_pkg;
    typedef enum logic [1:0] {OP_WRITE = 2'd0, OP_EVENT = 2'd1, OP_SERVICE = 2'd2,
                              OP_NOP = 2'd3} op_t;
    typedef enum logic [1:0] {REG_SRC = 2'd0, REG_DST = 2'd1, REG_CNT = 2'd2,
                              REG_CTL = 2'd3} reg_sel_t;

    localparam int ADDR_W = 28;
    localparam int UNITS_W = 17;

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  channel;
        logic [1:0]  reg_select;
        logic [31:0] value;
        logic [1:0]  timing;
        logic [7:0]  line;
    } item_t;

    typedef struct packed {
        logic              transfer_valid;
        logic [1:0]        xfer_channel;
        logic [ADDR_W-1:0] src_addr;
        logic [ADDR_W-1:0] dst_addr;
        logic              word_size;
        logic              src_nonseq;
        logic              dst_nonseq;
        logic              last_unit;
        logic              irq_request;
    } result_t;
endpackage
`default_nettype wire

// File: rtl/dae_front.sv
// ----------------------------------------------------------------------------
// DMA address engine front end
// Accept input words and queue them for the execution stage.
// ----------------------------------------------------------------------------
`default_nettype none
module dae_front (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire dae_pkg::item_t in_item,
    output logic                q_valid,
    input  wire logic           q_ready,
    output dae_pkg::item_t      q_item
);
    import dae_pkg::*;
    `include "four_channel_dma_address_engine_assert.svh"

    item_t      mem_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= in_item;
        end
    end

    `DAE_ASSERT(a_cnt_range, aclk, aresetn, cnt_reg != 2'd3)
    `DAE_ASSERT(a_full_stall, aclk, aresetn, (cnt_reg == 2'd2) |-> !in_ready)
    `DAE_ASSERT(a_ptr_eq, aclk, aresetn, (cnt_reg == 2'd0) |-> (wp_reg == rp_reg))
endmodule
`default_nettype wire

// File: rtl/dae_back.sv
// ----------------------------------------------------------------------------
// DMA address engine back end
// Execute writes, events and service steps; hold one result.
// ----------------------------------------------------------------------------
`default_nettype none
module dae_back #(
    parameter int FIFO_BURST = 4
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           vce,
    input  wire logic           q_valid,
    output logic                q_ready,
    input  wire dae_pkg::item_t q_item,
    output logic                out_valid,
    input  wire logic           out_ready,
    output dae_pkg::result_t    out_res
);
    import dae_pkg::*;
    `include "four_channel_dma_address_engine_assert.svh"

    localparam logic [UNITS_W-1:0] BURST = UNITS_W'(FIFO_BURST);

    logic [ADDR_W-1:0]  src_base_reg [4], src_base_next [4];
    logic [ADDR_W-1:0]  dst_base_reg [4], dst_base_next [4];
    logic [15:0]        cnt_base_reg [4], cnt_base_next [4];
    logic [15:0]        ctl_reg [4], ctl_next [4];
    logic [ADDR_W-1:0]  cur_src_reg [4], cur_src_next [4];
    logic [ADDR_W-1:0]  cur_dst_reg [4], cur_dst_next [4];
    logic [UNITS_W-1:0] left_reg [4], left_next [4];
    logic [3:0]         fifo_reg, fifo_next, video_reg, video_next;
    logic [3:0]         pend_reg, pend_next;
    logic               rom_reg, rom_next;
    logic               ov_reg, ov_next;
    result_t            res_reg, res_next;
    logic               go;

    function automatic logic [UNITS_W-1:0] full_cnt(input logic [1:0] c,
                                                    input logic [15:0] n);
        logic [15:0] m;
        m = (c == 2'd3) ? n : {2'b00, n[13:0]};
        if (m == 16'd0) begin
            full_cnt = (c == 2'd3) ? 17'h10000 : 17'h04000;
        end else begin
            full_cnt = {1'b0, m};
        end
    endfunction

    function automatic logic [ADDR_W-1:0] step(input logic [ADDR_W-1:0] a,
                                               input logic [1:0] md, input logic w);
        logic [ADDR_W-1:0] sz;
        sz = w ? ADDR_W'(4) : ADDR_W'(2);
        case (md)
            2'd0:    step = a + sz;
            2'd1:    step = a - sz;
            default: step = a;
        endcase
    endfunction

    assign q_ready   = !ov_reg || out_ready;
    assign go        = q_valid && q_ready;
    assign out_valid = ov_reg;
    assign out_res   = res_reg;

    always_comb begin
        logic [1:0]        c, sc, dm, sm, tim;
        logic [15:0]       v, ctl;
        logic              en, fin, s_in, d_in;
        logic [ADDR_W-1:0] al, sm_k, dm_k;
        src_base_next = src_base_reg;
        dst_base_next = dst_base_reg;
        cnt_base_next = cnt_base_reg;
        ctl_next      = ctl_reg;
        cur_src_next  = cur_src_reg;
        cur_dst_next  = cur_dst_reg;
        left_next     = left_reg;
        fifo_next     = fifo_reg;
        video_next    = video_reg;
        pend_next     = pend_reg;
        rom_next      = rom_reg;
        res_next      = '0;
        ov_next       = ov_reg && !out_ready;
        c   = q_item.channel;
        fin = 1'b0;
        sc  = 2'd0;
        v   = q_item.value[15:0];
        ctl = '0;
        dm  = '0;
        sm  = '0;
        tim = '0;
        en  = 1'b0;
        s_in = 1'b0;
        d_in = 1'b0;
        al   = '0;
        sm_k = '0;
        dm_k = '0;
        if (go) begin
            ov_next = 1'b1;
            case (q_item.op)
                OP_WRITE: begin
                    case (q_item.reg_select)
                        REG_SRC: src_base_next[c] = q_item.value[ADDR_W-1:0];
                        REG_DST: dst_base_next[c] = q_item.value[ADDR_W-1:0];
                        REG_CNT: cnt_base_next[c] = q_item.value[15:0];
                        default: begin
                            if (c != 2'd3) begin
                                v[11] = 1'b0;
                            end
                            ctl_next[c] = v;
                            if (!ctl_reg[c][15] && v[15]) begin
                                tim = v[13:12];
                                fifo_next[c]  = (c == 2'd1 || c == 2'd2) && tim == 2'd3;
                                video_next[c] = (c == 2'd3) && tim == 2'd3;
                                left_next[c]  = fifo_next[c] ? BURST
                                                : full_cnt(c, cnt_base_reg[c]);
                                al   = v[10] ? ~ADDR_W'(3) : ~ADDR_W'(1);
                                sm_k = (c == 2'd0) ? 28'h7FFFFFF : 28'hFFFFFFF;
                                dm_k = (c == 2'd3) ? 28'hFFFFFFF : 28'h7FFFFFF;
                                cur_src_next[c] = src_base_reg[c] & al & sm_k;
                                cur_dst_next[c] = dst_base_reg[c] & al & dm_k;
                                if (tim == 2'd0) begin
                                    pend_next[c] = 1'b1;
                                    rom_next     = 1'b0;
                                end
                            end else if (ctl_reg[c][15] && !v[15]) begin
                                pend_next[c] = 1'b0;
                                rom_next     = 1'b0;
                            end
                        end
                    endcase
                end
                OP_EVENT: begin
                    for (int i = 0; i < 4; i++) begin
                        en = (i == 3 && q_item.timing == 2'd3) ? vce : ctl_reg[i][15];
                        if (en && ctl_reg[i][13:12] == q_item.timing) begin
                            pend_next[i] = 1'b1;
                            rom_next     = 1'b0;
                        end
                    end
                end
                OP_SERVICE: begin
                    if (pend_reg != 4'd0) begin
                        sc = pend_reg[0] ? 2'd0 : pend_reg[1] ? 2'd1 :
                             pend_reg[2] ? 2'd2 : 2'd3;
                        ctl = ctl_reg[sc];
                        res_next.xfer_channel = sc;
                        if (left_reg[sc] == '0) begin
                            fin = 1'b1;
                        end else begin
                            dm = fifo_reg[sc] ? 2'd2 : ctl[6:5];
                            if (dm == 2'd3) begin
                                dm = 2'd0;
                            end
                            sm = ctl[8:7];
                            res_next.transfer_valid = 1'b1;
                            res_next.src_addr  = cur_src_reg[sc];
                            res_next.dst_addr  = cur_dst_reg[sc];
                            res_next.word_size = ctl[10];
                            if (!rom_reg) begin
                                s_in = cur_src_reg[sc][27];
                                d_in = cur_dst_reg[sc][27];
                                rom_next = s_in | d_in;
                                res_next.src_nonseq = s_in;
                                res_next.dst_nonseq = !s_in && d_in;
                            end
                            cur_src_next[sc] = step(cur_src_reg[sc], sm, ctl[10]);
                            cur_dst_next[sc] = step(cur_dst_reg[sc], dm, ctl[10]);
                            left_next[sc] = left_reg[sc] - UNITS_W'(1);
                            fin = (left_next[sc] == '0);
                        end
                        if (fin) begin
                            pend_next[sc] = 1'b0;
                            rom_next = 1'b0;
                            res_next.last_unit   = 1'b1;
                            res_next.irq_request = ctl[14];
                            al   = ctl[10] ? ~ADDR_W'(3) : ~ADDR_W'(1);
                            dm_k = (sc == 2'd3) ? 28'hFFFFFFF : 28'h7FFFFFF;
                            if (!ctl[9]) begin
                                ctl_next[sc][15] = 1'b0;
                            end else if (fifo_reg[sc]) begin
                                left_next[sc] = BURST;
                            end else if (video_reg[sc] && q_item.line >= 8'd161) begin
                                ctl_next[sc][15] = 1'b0;
                            end else begin
                                left_next[sc] = full_cnt(sc, cnt_base_reg[sc]);
                                if (ctl[6:5] == 2'd3) begin
                                    cur_dst_next[sc] = dst_base_reg[sc] & al & dm_k;
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                src_base_reg[i] <= '0;
                dst_base_reg[i] <= '0;
                cnt_base_reg[i] <= '0;
                ctl_reg[i]      <= '0;
                cur_src_reg[i]  <= '0;
                cur_dst_reg[i]  <= '0;
                left_reg[i]     <= '0;
            end
            fifo_reg  <= '0;
            video_reg <= '0;
            pend_reg  <= '0;
            rom_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end else begin
            src_base_reg <= src_base_next;
            dst_base_reg <= dst_base_next;
            cnt_base_reg <= cnt_base_next;
            ctl_reg      <= ctl_next;
            cur_src_reg  <= cur_src_next;
            cur_dst_reg  <= cur_dst_next;
            left_reg     <= left_next;
            fifo_reg     <= fifo_next;
            video_reg    <= video_next;
            pend_reg     <= pend_next;
            rom_reg      <= rom_next;
            ov_reg       <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            res_reg <= res_next;
        end
    end

    `DAE_ASSERT(a_hold, aclk, aresetn, (ov_reg && !out_ready) |=> $stable(res_reg))
    `DAE_ASSERT(a_irq_last, aclk, aresetn, (ov_reg && res_reg.irq_request) |-> res_reg.last_unit)
    `DAE_ASSERT(a_fifo_video, aclk, aresetn, (fifo_reg & video_reg) == 4'd0)
endmodule
`default_nettype wire

// File: rtl/four_channel_dma_address_engine.sv
// ----------------------------------------------------------------------------
// Four-channel DMA address engine
// Register writes, timing events and unit service steps in, one result out.
//
//   channel   dir  handshake            payload
//   s_axis    in   s_tvalid/s_tready    op, channel, reg_select, value, timing, line
//   m_axis    out  m_tvalid/m_tready    one result per input word
//   cfg       in   cfg_valid/cfg_ready  video_capture_enable
//
// One word per cycle sustained while m_tready is high; a word passes the queue,
// then its result is registered and shown on m_tvalid. A two-entry queue parts
// the accept stage from the execute stage, whose result register holds while
// m_tready is low. Reset is synchronous, aresetn low clears all channel state.
// ----------------------------------------------------------------------------
`default_nettype none
module four_channel_dma_address_engine #(
    parameter int FIFO_BURST = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // op[1:0], channel[3:2], reg_select[5:4], value[37:6], timing[39:38], line[47:40]
    input  wire logic [47:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // transfer_valid[0], xfer_channel[2:1], src_addr[30:3], dst_addr[58:31],
    // word_size[59], src_nonseq[60], dst_nonseq[61], irq_request[62]
    output logic [63:0]      m_tdata,
    // last_unit
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data
);
    import dae_pkg::*;

    item_t   in_item, q_item;
    result_t res;
    logic    q_valid, q_ready, vce_reg;

    assign in_item.op         = s_tdata[1:0];
    assign in_item.channel    = s_tdata[3:2];
    assign in_item.reg_select = s_tdata[5:4];
    assign in_item.value      = s_tdata[37:6];
    assign in_item.timing     = s_tdata[39:38];
    assign in_item.line       = s_tdata[47:40];

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vce_reg <= 1'b0;
        end else if (cfg_valid) begin
            vce_reg <= cfg_data;
        end
    end

    dae_front u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready), .in_item,
        .q_valid, .q_ready, .q_item
    );

    dae_back #(.FIFO_BURST(FIFO_BURST)) u_back (
        .aclk, .aresetn, .vce(vce_reg),
        .q_valid, .q_ready, .q_item,
        .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
    );

    assign m_tdata = {1'b0, res.irq_request, res.dst_nonseq, res.src_nonseq,
                      res.word_size, res.dst_addr, res.src_addr, res.xfer_channel,
                      res.transfer_valid};
    assign m_tlast = res.last_unit;
endmodule
`default_nettype wire

// File: sim/four_channel_dma_address_engine_checker.sv
// ----------------------------------------------------------------------------
// DMA address engine result checker
// Watches the input, result and config channels, keeps its own copy of the
// channel state, predicts one result per accepted word and compares in order.
// ----------------------------------------------------------------------------
`default_nettype none
module four_channel_dma_address_engine_checker
    import dae_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [47:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [63:0] m_tdata,
    input  wire logic        m_tlast,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic        cfg_data,
    output int               errors,
    output int               pending_results,
    output int               transfers_seen,
    output int               irqs_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [27:0] CART_BASE = 28'h8000000;
    localparam logic [27:0] SRC_LIMIT [4] = '{28'h7FFFFFF, 28'hFFFFFFF, 28'hFFFFFFF,
                                              28'hFFFFFFF};
    localparam logic [27:0] DST_LIMIT [4] = '{28'h7FFFFFF, 28'h7FFFFFF, 28'h7FFFFFF,
                                              28'hFFFFFFF};
    localparam logic [15:0] CNT_LIMIT [4] = '{16'h3FFF, 16'h3FFF, 16'h3FFF, 16'hFFFF};
    localparam int BURST = 4;

    logic        capture_en;
    logic [27:0] src_reg [4];
    logic [27:0] dst_reg [4];
    logic [15:0] cnt_reg [4];
    logic [15:0] ctl_reg [4];
    logic [27:0] src_ptr [4];
    logic [27:0] dst_ptr [4];
    logic [16:0] remaining [4];
    logic [3:0]  fifo_ch;
    logic [3:0]  video_ch;
    logic [3:0]  pend;
    logic        cart_hit;
    result_t     expected_q [$];

    function automatic logic [27:0] align(int c, logic [27:0] a);
        return ctl_reg[c][10] ? {a[27:2], 2'b00} : {a[27:1], 1'b0};
    endfunction

    function automatic logic [16:0] block_len(int c);
        logic [15:0] n;
        n = cnt_reg[c] & CNT_LIMIT[c];
        return n == 0 ? 17'(CNT_LIMIT[c]) + 17'd1 : 17'(n);
    endfunction

    function automatic logic [27:0] step(logic [27:0] a, logic [1:0] mode, logic word);
        logic [27:0] sz;
        sz = word ? 28'd4 : 28'd2;
        if (mode == 2'd0) return a + sz;
        if (mode == 2'd1) return a - sz;
        return a;
    endfunction

    task automatic trigger(int c, logic [1:0] tim);
        logic en;
        en = (c == 3 && tim == 2'd3) ? capture_en : ctl_reg[c][15];
        if (en && ctl_reg[c][13:12] == tim) begin
            pend[c] = 1'b1;
            cart_hit = 1'b0;
        end
    endtask

    task automatic end_block(int c, logic [7:0] line, inout result_t r);
        pend[c] = 1'b0;
        cart_hit = 1'b0;
        r.last_unit = 1'b1;
        r.irq_request = ctl_reg[c][14];
        if (!ctl_reg[c][9]) begin
            ctl_reg[c][15] = 1'b0;
        end else if (fifo_ch[c]) begin
            remaining[c] = BURST;
        end else if (video_ch[c] && line >= 8'd161) begin
            ctl_reg[c][15] = 1'b0;
        end else begin
            remaining[c] = block_len(c);
            if (ctl_reg[c][6:5] == 2'd3) dst_ptr[c] = align(c, dst_reg[c]) & DST_LIMIT[c];
        end
    endtask

    task automatic predict_dma(item_t it);
        result_t r;
        int c;
        logic [15:0] v;
        logic [1:0] dmode;
        logic s_in, d_in;
        r = '0;
        c = it.channel;
        case (it.op)
            OP_WRITE: begin
                case (it.reg_select)
                    REG_SRC: src_reg[c] = it.value[27:0];
                    REG_DST: dst_reg[c] = it.value[27:0];
                    REG_CNT: cnt_reg[c] = it.value[15:0];
                    default: begin
                        v = it.value[15:0];
                        if (c != 3) v[11] = 1'b0;
                        if (!ctl_reg[c][15] && v[15]) begin
                            ctl_reg[c] = v;
                            fifo_ch[c] = (c == 1 || c == 2) && v[13:12] == 2'd3;
                            video_ch[c] = c == 3 && v[13:12] == 2'd3;
                            remaining[c] = fifo_ch[c] ? 17'(BURST) : block_len(c);
                            src_ptr[c] = align(c, src_reg[c]) & SRC_LIMIT[c];
                            dst_ptr[c] = align(c, dst_reg[c]) & DST_LIMIT[c];
                            if (v[13:12] == 2'd0) trigger(c, 2'd0);
                        end else begin
                            if (ctl_reg[c][15] && !v[15]) begin
                                pend[c] = 1'b0;
                                cart_hit = 1'b0;
                            end
                            ctl_reg[c] = v;
                        end
                    end
                endcase
            end
            OP_EVENT: for (int i = 0; i < 4; i++) trigger(i, it.timing);
            OP_SERVICE: if (pend != 0) begin
                c = pend[0] ? 0 : pend[1] ? 1 : pend[2] ? 2 : 3;
                r.xfer_channel = 2'(c);
                if (remaining[c] == 0) begin
                    end_block(c, it.line, r);
                end else begin
                    dmode = fifo_ch[c] ? 2'd2 : ctl_reg[c][6:5];
                    if (dmode == 2'd3) dmode = 2'd0;
                    r.transfer_valid = 1'b1;
                    r.src_addr = src_ptr[c];
                    r.dst_addr = dst_ptr[c];
                    r.word_size = ctl_reg[c][10];
                    if (!cart_hit) begin
                        s_in = src_ptr[c] >= CART_BASE;
                        d_in = dst_ptr[c] >= CART_BASE;
                        cart_hit = s_in | d_in;
                        r.src_nonseq = s_in;
                        r.dst_nonseq = !s_in && d_in;
                    end
                    src_ptr[c] = step(src_ptr[c], ctl_reg[c][8:7], ctl_reg[c][10]);
                    dst_ptr[c] = step(dst_ptr[c], dmode, ctl_reg[c][10]);
                    remaining[c] = remaining[c] - 17'd1;
                    if (remaining[c] == 0) end_block(c, it.line, r);
                end
            end
            default: ;
        endcase
        expected_q.push_back(r);
    endtask

    task automatic compare_result(result_t exp_r, logic [63:0] d, logic last);
        result_t got;
        got.transfer_valid = d[0];
        got.xfer_channel = d[2:1];
        got.src_addr = d[30:3];
        got.dst_addr = d[58:31];
        got.word_size = d[59];
        got.src_nonseq = d[60];
        got.dst_nonseq = d[61];
        got.irq_request = d[62];
        got.last_unit = last;
        if (got !== exp_r) begin
            errors++;
            $display("%0t mismatch: expected %p", $time, exp_r);
            $display("%0t           actual   %p", $time, got);
        end
        if (got.transfer_valid) transfers_seen++;
        if (got.irq_request) irqs_seen++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            capture_en = 1'b0;
            for (int i = 0; i < 4; i++) begin
                src_reg[i] = '0; dst_reg[i] = '0; cnt_reg[i] = '0; ctl_reg[i] = '0;
                src_ptr[i] = '0; dst_ptr[i] = '0; remaining[i] = '0;
            end
            fifo_ch = '0; video_ch = '0; pend = '0; cart_hit = 1'b0;
            expected_q.delete();
            errors = 0; transfers_seen = 0; irqs_seen = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    errors++;
                    $display("%0t unexpected result word %h", $time, m_tdata);
                end else begin
                    compare_result(expected_q.pop_front(), m_tdata, m_tlast);
                end
            end
            if (cfg_valid && cfg_ready) capture_en = cfg_data;
            if (s_tvalid && s_tready) begin
                predict_dma('{op: s_tdata[1:0], channel: s_tdata[3:2],
                              reg_select: s_tdata[5:4], value: s_tdata[37:6],
                              timing: s_tdata[39:38], line: s_tdata[47:40]});
            end
        end
        pending_results = expected_q.size();
    end
endmodule
`default_nettype wire

// File: sim/four_channel_dma_address_engine_tb.sv
// ----------------------------------------------------------------------------
// DMA address engine testbench
// Drives register writes, timing events and service steps in bursts with a
// stalling receiver, toggles video capture between phases, reports verdict.
// ----------------------------------------------------------------------------
`default_nettype none
module four_channel_dma_address_engine_tb;
    import dae_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;
    int          errors, pending_results, transfers_seen, irqs_seen;
    int          cycles = 0;
    int          hold_off = 0;
    int          words_sent = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    four_channel_dma_address_engine uut (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready,
        .m_tdata, .m_tlast, .cfg_valid, .cfg_ready, .cfg_data
    );

    four_channel_dma_address_engine_checker chk (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready,
        .m_tdata, .m_tlast, .cfg_valid, .cfg_ready, .cfg_data, .errors,
        .pending_results, .transfers_seen, .irqs_seen
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else if (cycles % 300 < 100) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic send_word(logic [1:0] op, logic [1:0] ch, logic [1:0] sel,
                             logic [31:0] val, logic [1:0] tim, logic [7:0] line);
        s_tdata <= {line, tim, val, sel, ch, op};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        words_sent++;
    endtask

    task automatic pause_sender(int n);
        s_tvalid <= 1'b0;
        repeat (n) @(negedge aclk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_results != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic set_capture(logic en);
        cfg_data <= en;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_channel(logic [1:0] ch, logic [31:0] src, logic [31:0] dst,
                                   logic [31:0] cnt, logic [31:0] ctl);
        send_word(OP_WRITE, ch, REG_SRC, src, 2'd0, 8'd0);
        send_word(OP_WRITE, ch, REG_DST, dst, 2'd0, 8'd0);
        send_word(OP_WRITE, ch, REG_CNT, cnt, 2'd0, 8'd0);
        send_word(OP_WRITE, ch, REG_CTL, ctl, 2'd0, 8'd0);
    endtask

    task automatic random_word(int gap_chance);
        logic [1:0] op;
        logic [31:0] v;
        logic [31:0] r;
        r = $urandom_range(0, 99);
        op = r < 30 ? OP_WRITE : r < 45 ? OP_EVENT : r < 97 ? OP_SERVICE : OP_NOP;
        v = $urandom;
        if (op == OP_WRITE && $urandom_range(0, 3) != 0) begin
            v = {$urandom_range(0, 1) ? 4'h8 : 4'h0, v[27:0]};
            if ($urandom_range(0, 1)) v[15:0] = 16'($urandom_range(0, 6));
            if ($urandom_range(0, 1)) v[15] = 1'b1;
        end
        send_word(op, 2'($urandom), 2'($urandom), v, 2'($urandom),
                  8'($urandom_range(0, 227)));
        if ($urandom_range(0, 99) < gap_chance) pause_sender($urandom_range(1, 6));
    endtask

    initial begin
        logic [31:0] ctl;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        program_channel(2'd0, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0003, 32'h0000_C400);
        repeat (4) send_word(OP_SERVICE, 2'd0, 2'd0, 32'd0, 2'd0, 8'd0);
        program_channel(2'd3, 32'h0800_0002, 32'h0FFF_FFFE, 32'h0000_0002, 32'h0000_C860);
        send_word(OP_SERVICE, 2'd0, 2'd0, 32'd0, 2'd0, 8'd227);
        send_word(OP_SERVICE, 2'd0, 2'd0, 32'd0, 2'd0, 8'd160);
        send_word(OP_NOP, 2'd3, 2'd3, 32'hFFFF_FFFF, 2'd3, 8'hFF);
        drain();
        set_capture(1'b1);
        send_word(OP_EVENT, 2'd0, 2'd0, 32'd0, 2'd3, 8'd0);
        send_word(OP_SERVICE, 2'd0, 2'd0, 32'd0, 2'd0, 8'd100);
        program_channel(2'd1, 32'h0000_0000, 32'h0400_00A0, 32'd0, 32'hB600);
        send_word(OP_EVENT, 2'd0, 2'd0, 32'd0, 2'd3, 8'd0);
        repeat (5) send_word(OP_SERVICE, 2'd0, 2'd0, 32'd0, 2'd0, 8'd0);
        send_word(OP_WRITE, 2'd1, REG_CTL, 32'd0, 2'd0, 8'd0);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            set_capture(phase[0]);
            if (phase == 2) hold_off = 200;
            for (int n = 0; n < 140; n++) begin
                if ($urandom_range(0, 9) < 3) begin
                    ctl = $urandom;
                    ctl[15] = 1'b1;
                    ctl[9] = $urandom_range(0, 1);
                    program_channel(2'($urandom), $urandom, $urandom,
                                    $urandom_range(0, 5), ctl);
                    n += 4;
                end
                random_word(phase == 2 ? 0 : 20);
            end
            drain();
        end

        $display("sent %0d words; %0d transfer units and %0d interrupts checked",
                 words_sent, transfers_seen, irqs_seen);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
+incdir+rtl
rtl/dae_pkg.sv
rtl/dae_front.sv
rtl/dae_back.sv
rtl/four_channel_dma_address_engine.sv
sim/four_channel_dma_address_engine_checker.sv
sim/four_channel_dma_address_engine_tb.sv
